FILE: hw/rtl/vdia_pkg.sv
// Shared constants and word types of the vertex deduplication block.
`timescale 1ns / 1ps

package vdia_pkg;

   localparam int POS_W    = 32;
   localparam int COLOUR_W = 10;
   localparam int VTX_W    = 3 * POS_W + COLOUR_W;
   localparam int UIDX_W   = 12;

   localparam int DEF_CAPACITY   = 4096;
   localparam int DEF_HASH_SLOTS = 8192;

   localparam logic [POS_W-1:0] FNV_OFFSET = 32'h811C_9DC5;
   localparam logic [POS_W-1:0] FNV_PRIME  = 32'h0100_0193;

   typedef struct packed {
      logic                first_of_set;
      logic [POS_W-1:0]    pos_x;
      logic [POS_W-1:0]    pos_y;
      logic [POS_W-1:0]    pos_z;
      logic [COLOUR_W-1:0] colour_index;
   } vdia_req_type;

   typedef struct packed {
      logic [UIDX_W-1:0] unique_index;
      logic              is_new;
      logic              overflow;
   } vdia_rsp_type;

endpackage

FILE: hw/rtl/vdia_stream_if.sv
// Valid/ready stream interface that carries one word per handshake.
`timescale 1ns / 1ps

interface vdia_stream_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/vdia_hash.sv
// Multi-cycle vertex hash: four multiply rounds, a fold and a reduction to a home slot.
`timescale 1ns / 1ps

module vdia_hash #(
   parameter int HASH_SLOTS = vdia_pkg::DEF_HASH_SLOTS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [vdia_pkg::POS_W-1:0]        pos_x,
   input  logic [vdia_pkg::POS_W-1:0]        pos_y,
   input  logic [vdia_pkg::POS_W-1:0]        pos_z,
   input  logic [vdia_pkg::COLOUR_W-1:0]     colour_index,
   output logic                              done,
   output logic [$clog2(HASH_SLOTS)-1:0]     slot
);

   localparam int SLOT_W    = $clog2(HASH_SLOTS);
   localparam bit SLOT_POW2 = (HASH_SLOTS & (HASH_SLOTS - 1)) == 0;
   localparam int MOD_BITS  = 4;
   localparam logic [2:0] MIX_LAST = 3'd3;
   localparam logic [2:0] MOD_LAST = 3'(vdia_pkg::POS_W / MOD_BITS - 1);

   localparam logic [1:0] HS_IDLE = 2'd0;
   localparam logic [1:0] HS_MIX  = 2'd1;
   localparam logic [1:0] HS_MOD  = 2'd2;

   localparam logic [SLOT_W:0] SLOTS_EXT = (SLOT_W + 1)'(HASH_SLOTS);

   logic [1:0]                     state_ff, state_in;
   logic [2:0]                     step_ff, step_in;
   logic [vdia_pkg::POS_W-1:0]     h_ff, h_in;
   logic [vdia_pkg::POS_W-1:0]     y_ff, y_in;
   logic [vdia_pkg::POS_W-1:0]     z_ff, z_in;
   logic [vdia_pkg::COLOUR_W-1:0]  c_ff, c_in;
   logic [SLOT_W-1:0]              rem_ff, rem_in;
   logic                           done_ff, done_in;
   logic [SLOT_W-1:0]              slot_ff, slot_in;

   logic [vdia_pkg::POS_W-1:0]     prod;
   logic [vdia_pkg::POS_W-1:0]     mix_word;
   logic [SLOT_W-1:0]              rem_step;
   logic [SLOT_W:0]                trial;

   assign prod = h_ff * vdia_pkg::FNV_PRIME;

   always_comb begin
      case (step_ff)
         3'd0:    mix_word = y_ff;
         3'd1:    mix_word = z_ff;
         default: mix_word = vdia_pkg::POS_W'(c_ff);
      endcase
   end

   // Long division of the hash by the slot count, four bits per cycle from the top.
   always_comb begin
      rem_step = rem_ff;
      trial    = '0;
      for (int i = 0; i < MOD_BITS; i++) begin
         trial = {rem_step, h_ff[vdia_pkg::POS_W-1-i]};
         if (trial >= SLOTS_EXT) begin
            trial = trial - SLOTS_EXT;
         end
         rem_step = trial[SLOT_W-1:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      h_in     = h_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      c_in     = c_ff;
      rem_in   = rem_ff;
      done_in  = 1'b0;
      slot_in  = slot_ff;
      case (state_ff)
         HS_IDLE: begin
            if (start) begin
               h_in     = vdia_pkg::FNV_OFFSET ^ pos_x;
               y_in     = pos_y;
               z_in     = pos_z;
               c_in     = colour_index;
               step_in  = '0;
               state_in = HS_MIX;
            end
         end
         HS_MIX: begin
            step_in = step_ff + 3'd1;
            if (step_ff == MIX_LAST) begin
               h_in     = prod ^ (prod >> 15);
               step_in  = '0;
               rem_in   = '0;
               state_in = HS_MOD;
            end else begin
               h_in = prod ^ mix_word;
            end
         end
         HS_MOD: begin
            if (SLOT_POW2) begin
               slot_in  = h_ff[SLOT_W-1:0];
               done_in  = 1'b1;
               state_in = HS_IDLE;
            end else begin
               rem_in  = rem_step;
               h_in    = h_ff << MOD_BITS;
               step_in = step_ff + 3'd1;
               if (step_ff == MOD_LAST) begin
                  slot_in  = rem_step;
                  done_in  = 1'b1;
                  state_in = HS_IDLE;
               end
            end
         end
         default: begin
            state_in = HS_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= HS_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      step_ff <= step_in;
      h_ff    <= h_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      c_ff    <= c_in;
      rem_ff  <= rem_in;
      slot_ff <= slot_in;
   end

   assign done = done_ff;
   assign slot = slot_ff;

endmodule

FILE: hw/rtl/vertex_dedup_index_assigner.sv
// Top level: vertex deduplication with a hashed slot table and a vertex store.
//
//   channel | dir | handshake         | word
//   req_if  | in  | valid/ready       | first_of_set, pos_x, pos_y, pos_z, colour_index
//   rsp_if  | out | valid/ready       | unique_index, is_new, overflow
//
// One vertex at a time, in steps: accept, hash (four multiply rounds, a reduction and
// picking up the slot; the reduction is a long division when the slot count is not a
// power of two), per probe a slot read, a store read and a compare and write, then out.
// After reset the input is held off while the slot table is zeroed; later a slot is live
// only if its index is below the count and that vertex names it.
// A waiting result holds the next vertex only at its own output register.
`timescale 1ns / 1ps

module vertex_dedup_index_assigner #(
   parameter int CAPACITY   = vdia_pkg::DEF_CAPACITY,
   parameter int HASH_SLOTS = vdia_pkg::DEF_HASH_SLOTS
) (
   input  logic                 clock,
   input  logic                 reset,
   vdia_stream_if.sink          req_if,
   vdia_stream_if.source        rsp_if
);

   localparam int IDX_W   = $clog2(CAPACITY);
   localparam int CNT_W   = $clog2(CAPACITY + 1);
   localparam int SLOT_W  = $clog2(HASH_SLOTS);
   localparam int STORE_W = vdia_pkg::VTX_W + SLOT_W;
   localparam int UIDX_W  = vdia_pkg::UIDX_W;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_HASH  = 3'd1;
   localparam logic [2:0] S_PROBE = 3'd2;
   localparam logic [2:0] S_TBL   = 3'd3;
   localparam logic [2:0] S_CMP   = 3'd4;
   localparam logic [2:0] S_RESP  = 3'd5;
   localparam logic [2:0] S_CLEAR = 3'd6;

   logic [2:0]                   state_ff, state_in;
   logic [vdia_pkg::VTX_W-1:0]   vtx_ff, vtx_in;
   logic [CNT_W-1:0]             count_ff, count_in;
   logic [SLOT_W-1:0]            slot_ff, slot_in;
   logic [SLOT_W-1:0]            probes_ff, probes_in;
   logic [IDX_W-1:0]             res_idx_ff, res_idx_in;
   logic                         res_new_ff, res_new_in;
   logic                         res_ovf_ff, res_ovf_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   vdia_pkg::vdia_rsp_type       rsp_data_ff, rsp_data_in;

   logic [IDX_W-1:0]             table_mem [HASH_SLOTS];
   logic [STORE_W-1:0]           store_mem [CAPACITY];
   logic [IDX_W-1:0]             tbl_q_ff;
   logic [STORE_W-1:0]           st_q_ff;

   logic                         req_accept;
   logic                         hash_done;
   logic [SLOT_W-1:0]            hash_slot;
   logic                         tbl_we;
   logic                         st_we;
   logic                         entry_live;
   logic                         entry_match;
   logic                         has_room;
   logic                         last_probe;
   logic                         out_free;
   logic [IDX_W+UIDX_W-1:0]      idx_ext;

   assign req_accept = req_if.valid && (state_ff == S_IDLE);

   vdia_hash #(
      .HASH_SLOTS(HASH_SLOTS)
   ) u_hash (
      .clock        (clock),
      .reset        (reset),
      .start        (req_accept),
      .pos_x        (req_if.data.pos_x),
      .pos_y        (req_if.data.pos_y),
      .pos_z        (req_if.data.pos_z),
      .colour_index (req_if.data.colour_index),
      .done         (hash_done),
      .slot         (hash_slot)
   );

   // Slot table: holds a store index per slot. The count is zero during the clearing
   // pass, so the same write port zeroes the table.
   always_ff @(posedge clock) begin
      if (tbl_we) begin
         table_mem[slot_ff] <= count_ff[IDX_W-1:0];
      end
      tbl_q_ff <= table_mem[slot_ff];
   end

   // Vertex store: the vertex words plus the slot that points at the entry.
   always_ff @(posedge clock) begin
      if (st_we) begin
         store_mem[count_ff[IDX_W-1:0]] <= {vtx_ff, slot_ff};
      end
      st_q_ff <= store_mem[tbl_q_ff];
   end

   // A slot is occupied only if its index is live and that entry names this slot back.
   assign entry_live  = (CNT_W'(tbl_q_ff) < count_ff) && (st_q_ff[SLOT_W-1:0] == slot_ff);
   assign entry_match = st_q_ff[STORE_W-1:SLOT_W] == vtx_ff;
   assign has_room    = count_ff < CNT_W'(CAPACITY);
   assign last_probe  = probes_ff == SLOT_W'(HASH_SLOTS - 1);
   assign out_free    = !rsp_valid_ff || rsp_if.ready;
   assign idx_ext     = {UIDX_W'(0), res_idx_ff};

   always_comb begin
      state_in     = state_ff;
      vtx_in       = vtx_ff;
      count_in     = count_ff;
      slot_in      = slot_ff;
      probes_in    = probes_ff;
      res_idx_in   = res_idx_ff;
      res_new_in   = res_new_ff;
      res_ovf_in   = res_ovf_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_data_in  = rsp_data_ff;
      tbl_we       = 1'b0;
      st_we        = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            tbl_we = 1'b1;
            if (slot_ff == SLOT_W'(HASH_SLOTS - 1)) begin
               state_in = S_IDLE;
            end else begin
               slot_in = slot_ff + SLOT_W'(1);
            end
         end
         S_IDLE: begin
            if (req_if.valid) begin
               vtx_in = {req_if.data.pos_x, req_if.data.pos_y,
                         req_if.data.pos_z, req_if.data.colour_index};
               if (req_if.data.first_of_set) begin
                  count_in = '0;
               end
               state_in = S_HASH;
            end
         end
         S_HASH: begin
            if (hash_done) begin
               slot_in   = hash_slot;
               probes_in = '0;
               state_in  = S_PROBE;
            end
         end
         S_PROBE: begin
            state_in = S_TBL;
         end
         S_TBL: begin
            state_in = S_CMP;
         end
         S_CMP: begin
            res_idx_in = '0;
            res_new_in = 1'b0;
            res_ovf_in = 1'b1;
            state_in   = S_RESP;
            if (!entry_live) begin
               if (has_room) begin
                  tbl_we     = 1'b1;
                  st_we      = 1'b1;
                  res_idx_in = count_ff[IDX_W-1:0];
                  res_new_in = 1'b1;
                  res_ovf_in = 1'b0;
                  count_in   = count_ff + CNT_W'(1);
               end
            end else if (entry_match) begin
               res_idx_in = tbl_q_ff;
               res_ovf_in = 1'b0;
            end else if (!last_probe) begin
               slot_in   = (slot_ff == SLOT_W'(HASH_SLOTS - 1)) ? '0 : slot_ff + SLOT_W'(1);
               probes_in = probes_ff + SLOT_W'(1);
               state_in  = S_PROBE;
            end
         end
         S_RESP: begin
            if (out_free) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.unique_index = idx_ext[UIDX_W-1:0];
               rsp_data_in.is_new       = res_new_ff;
               rsp_data_in.overflow     = res_ovf_ff;
               state_in                 = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         count_ff     <= '0;
         slot_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         slot_ff      <= slot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      vtx_ff      <= vtx_in;
      probes_ff   <= probes_in;
      res_idx_ff  <= res_idx_in;
      res_new_ff  <= res_new_in;
      res_ovf_ff  <= res_ovf_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_if.ready = state_ff == S_IDLE;
   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.data  = rsp_data_ff;

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("vertex count exceeds the store capacity");

   a_new_not_overflow: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff.is_new && rsp_data_ff.overflow))
      else $error("word flags both a new entry and an overflow");

   a_append_counts: assert property (@(posedge clock) disable iff (reset)
      st_we |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("append did not advance the vertex count by one");

   a_hash_in_order: assert property (@(posedge clock) disable iff (reset)
      hash_done |-> state_ff == S_HASH)
      else $error("hash finished while no vertex was waiting for it");

endmodule
